@@ rtl/core/dahdsr_pkg.sv @@
// Shared widths, defaults, register indices and the config and divider item types for the DAHDSR envelope level block.
`timescale 1ns / 1ps
package dahdsr_pkg;
    localparam int SAMPLE_RATE_DEF = 48000;
    localparam int END_LEVEL_DEF   = 0;
    localparam int LVL_W  = 16;
    localparam int IDX_W  = 32;
    localparam int CFG_IW = 4;
    localparam int NREGS  = 8;
    localparam int SUM_W  = 18;
    localparam int TW     = 42;
    localparam int EW     = 36;
    localparam int RW     = 52;
    localparam int QW     = 16;

    localparam logic [CFG_IW-1:0] REG_INIT    = 4'd0;
    localparam logic [CFG_IW-1:0] REG_DELAY   = 4'd1;
    localparam logic [CFG_IW-1:0] REG_ATTACK  = 4'd2;
    localparam logic [CFG_IW-1:0] REG_PEAK    = 4'd3;
    localparam logic [CFG_IW-1:0] REG_HOLD    = 4'd4;
    localparam logic [CFG_IW-1:0] REG_DECAY   = 4'd5;
    localparam logic [CFG_IW-1:0] REG_SUSTAIN = 4'd6;
    localparam logic [CFG_IW-1:0] REG_RELEASE = 4'd7;

    typedef struct packed {
        logic [LVL_W-1:0] initial_level;
        logic [LVL_W-1:0] delay_ms;
        logic [LVL_W-1:0] attack_ms;
        logic [LVL_W-1:0] peak_level;
        logic [LVL_W-1:0] hold_ms;
        logic [LVL_W-1:0] decay_ms;
        logic [LVL_W-1:0] sustain_level;
        logic [LVL_W-1:0] release_ms;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [LVL_W-1:0] base;
        logic             down;
        logic             fin;
        logic [RW-1:0]    rem;
        logic [EW-1:0]    den;
        logic [QW-1:0]    quo;
    } div_item_t;
endpackage

@@ rtl/core/dahdsr_seg.sv @@
// Time scaling, segment selection and ramp product stages.
`timescale 1ns / 1ps
module dahdsr_seg #(
    parameter int SAMPLE_RATE = dahdsr_pkg::SAMPLE_RATE_DEF,
    parameter int END_LEVEL   = dahdsr_pkg::END_LEVEL_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [dahdsr_pkg::IDX_W-1:0]      sample_index,
    input  logic                              active_phase,
    input  dahdsr_pkg::cfg_t                  cfg,
    output dahdsr_pkg::div_item_t             item
);
    import dahdsr_pkg::*;

    localparam logic [LVL_W-1:0] END_LVL = LVL_W'(END_LEVEL);

    logic            v1_reg, v2_reg, v3_reg;
    logic            act1_reg;
    logic [TW-1:0]   t1_reg;
    logic [EW-1:0]   e_dly_reg, e_att_reg, e_hold_reg, e_dec_reg;
    logic [EW-1:0]   sp_att_reg, sp_dec_reg, sp_rel_reg;

    logic [SUM_W-1:0] s_att, s_hold, s_dec;
    logic [LVL_W-1:0] a_next, b_next;
    logic [TW-1:0]    el_wide;
    logic [EW-1:0]    sp_next;
    logic             ramp_next, fin_next;

    logic [LVL_W-1:0] base2_reg, diff2_reg;
    logic             down2_reg, fin2_reg;
    logic [EW-1:0]    el2_reg, sp2_reg;

    logic [LVL_W-1:0] base3_reg;
    logic             down3_reg, fin3_reg;
    logic [RW-1:0]    prod3_reg;
    logic [EW-1:0]    sp3_reg;

    assign s_att  = SUM_W'(cfg.delay_ms) + SUM_W'(cfg.attack_ms);
    assign s_hold = s_att + SUM_W'(cfg.hold_ms);
    assign s_dec  = s_hold + SUM_W'(cfg.decay_ms);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        act1_reg   <= active_phase;
        t1_reg     <= TW'(sample_index) * TW'(1000);
        e_dly_reg  <= EW'(cfg.delay_ms) * EW'(SAMPLE_RATE);
        e_att_reg  <= EW'(s_att) * EW'(SAMPLE_RATE);
        e_hold_reg <= EW'(s_hold) * EW'(SAMPLE_RATE);
        e_dec_reg  <= EW'(s_dec) * EW'(SAMPLE_RATE);
        sp_att_reg <= EW'(cfg.attack_ms) * EW'(SAMPLE_RATE);
        sp_dec_reg <= EW'(cfg.decay_ms) * EW'(SAMPLE_RATE);
        sp_rel_reg <= EW'(cfg.release_ms) * EW'(SAMPLE_RATE);
    end

    always_comb
    begin
        a_next    = cfg.sustain_level;
        b_next    = cfg.sustain_level;
        el_wide   = '0;
        sp_next   = EW'(1);
        ramp_next = 1'b0;
        fin_next  = 1'b0;
        if (act1_reg)
        begin
            if (t1_reg <= TW'(e_dly_reg))
            begin
                a_next = cfg.initial_level;
            end
            else if (t1_reg <= TW'(e_att_reg))
            begin
                a_next    = cfg.initial_level;
                b_next    = cfg.peak_level;
                el_wide   = t1_reg - TW'(e_dly_reg);
                sp_next   = sp_att_reg;
                ramp_next = 1'b1;
            end
            else if (t1_reg <= TW'(e_hold_reg))
            begin
                a_next = cfg.peak_level;
            end
            else if (t1_reg <= TW'(e_dec_reg))
            begin
                a_next    = cfg.peak_level;
                b_next    = cfg.sustain_level;
                el_wide   = t1_reg - TW'(e_hold_reg);
                sp_next   = sp_dec_reg;
                ramp_next = 1'b1;
            end
        end
        else if (t1_reg <= TW'(sp_rel_reg))
        begin
            if (sp_rel_reg != '0)
            begin
                b_next    = END_LVL;
                el_wide   = t1_reg;
                sp_next   = sp_rel_reg;
                ramp_next = 1'b1;
            end
        end
        else
        begin
            a_next   = END_LVL;
            fin_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        base2_reg <= a_next;
        down2_reg <= (b_next < a_next);
        diff2_reg <= !ramp_next ? '0 : (b_next < a_next) ? a_next - b_next : b_next - a_next;
        el2_reg   <= EW'(el_wide);
        sp2_reg   <= sp_next;
        fin2_reg  <= fin_next;
    end

    always_ff @(posedge clk)
    begin
        base3_reg <= base2_reg;
        down3_reg <= down2_reg;
        fin3_reg  <= fin2_reg;
        sp3_reg   <= sp2_reg;
        prod3_reg <= RW'(diff2_reg) * RW'(el2_reg);
    end

    always_comb
    begin
        item       = '0;
        item.valid = v3_reg;
        item.base  = base3_reg;
        item.down  = down3_reg;
        item.fin   = fin3_reg;
        item.rem   = prod3_reg;
        item.den   = sp3_reg;
        item.quo   = '0;
    end
endmodule

@@ rtl/core/dahdsr_div_stage.sv @@
// One restoring quotient bit of the ramp divider, registered.
`timescale 1ns / 1ps
module dahdsr_div_stage #(
    parameter int K = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dahdsr_pkg::div_item_t in_item,
    output dahdsr_pkg::div_item_t out_item
);
    import dahdsr_pkg::*;

    logic [RW-1:0] sub;
    logic          take;
    div_item_t     item_next;
    logic          valid_reg;
    div_item_t     item_reg;

    assign sub  = RW'(in_item.den) << K;
    assign take = (in_item.rem >= sub);

    always_comb
    begin
        item_next = in_item;
        if (take)
        begin
            item_next.rem    = in_item.rem - sub;
            item_next.quo[K] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_comb
    begin
        out_item       = item_reg;
        out_item.valid = valid_reg;
    end
endmodule

@@ rtl/core/dahdsr_envelope_level.sv @@
// Top level of the DAHDSR envelope level block: registers, pipeline and result stage.
//
//  Channel | Handshake        | Payload
//  --------+------------------+------------------------------
//  item in | start, busy      | sample_index, active_phase
//  result  | done             | level, finished
//  config  | cfg_we           | cfg_index, cfg_data
//
// One item is taken every cycle. The pipeline is the three front stages, the 16
// quotient stages of the ramp divider and the result register. busy stays low.
// Reset clears the valid bits and loads register defaults; items in flight are lost.
// The receiver cannot stall, so nothing ever backs up.
`timescale 1ns / 1ps
module dahdsr_envelope_level #(
    parameter int SAMPLE_RATE = dahdsr_pkg::SAMPLE_RATE_DEF,
    parameter int END_LEVEL   = dahdsr_pkg::END_LEVEL_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dahdsr_pkg::IDX_W-1:0]      sample_index,
    input  logic                              active_phase,
    output logic                              done,
    output logic [dahdsr_pkg::LVL_W-1:0]      level,
    output logic                              finished,
    input  logic                              cfg_we,
    input  logic [dahdsr_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [dahdsr_pkg::LVL_W-1:0]      cfg_data
);
    import dahdsr_pkg::*;

    cfg_t      cfg_reg;
    div_item_t stage [QW+1];
    logic      done_reg, fin_reg;
    logic [LVL_W-1:0] level_reg;
    div_item_t last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_level <= 16'd0;
            cfg_reg.delay_ms      <= 16'd0;
            cfg_reg.attack_ms     <= 16'd5;
            cfg_reg.peak_level    <= 16'd32768;
            cfg_reg.hold_ms       <= 16'd0;
            cfg_reg.decay_ms      <= 16'd50;
            cfg_reg.sustain_level <= 16'd16384;
            cfg_reg.release_ms    <= 16'd50;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INIT:    cfg_reg.initial_level <= cfg_data;
                REG_DELAY:   cfg_reg.delay_ms      <= cfg_data;
                REG_ATTACK:  cfg_reg.attack_ms     <= cfg_data;
                REG_PEAK:    cfg_reg.peak_level    <= cfg_data;
                REG_HOLD:    cfg_reg.hold_ms       <= cfg_data;
                REG_DECAY:   cfg_reg.decay_ms      <= cfg_data;
                REG_SUSTAIN: cfg_reg.sustain_level <= cfg_data;
                REG_RELEASE: cfg_reg.release_ms    <= cfg_data;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    dahdsr_seg #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .END_LEVEL   (END_LEVEL)
    ) u_seg (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .sample_index (sample_index),
        .active_phase (active_phase),
        .cfg          (cfg_reg),
        .item         (stage[0])
    );

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        dahdsr_div_stage #(
            .K (QW - 1 - i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_item  (stage[i]),
            .out_item (stage[i+1])
        );
    end

    assign last = stage[QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= last.down ? last.base - last.quo : last.base + last.quo;
        fin_reg   <= last.fin;
    end

    assign done     = done_reg;
    assign level    = level_reg;
    assign finished = fin_reg;
endmodule

@@ tb/tb_dahdsr_envelope_level.sv @@
// Self-checking testbench for the DAHDSR envelope level block: directed and random items.
`timescale 1ns / 1ps
module tb_dahdsr_envelope_level;
    import dahdsr_pkg::*;

    localparam int SR = 48000;
    localparam logic [15:0] END_LVL = 16'd0;
    localparam logic [CFG_IW-1:0] REG_UNUSED = 4'd11;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             act;
    } sample_t;

    typedef struct {
        logic [LVL_W-1:0] lvl;
        logic             fin;
    } envelope_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [IDX_W-1:0]    sample_index = '0;
    logic                active_phase = 1'b0;
    logic                done;
    logic [LVL_W-1:0]    level;
    logic                finished;
    logic                cfg_we = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [LVL_W-1:0]   cfg_data = '0;

    logic [LVL_W-1:0]    env_regs [NREGS];
    sample_t             pending_samples [$];
    envelope_t           expected_levels [$];
    int                  sender_idle_pct = 0;
    int                  mismatches = 0;
    int                  levels_checked = 0;
    int                  finished_seen = 0;
    int                  cycles = 0;

    dahdsr_envelope_level dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_index(sample_index), .active_phase(active_phase),
        .done(done), .level(level), .finished(finished),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned ramp_level(longint unsigned a, longint unsigned b,
                                                   longint unsigned el, longint unsigned span);
        if (span == 0)
            return a;
        if (b >= a)
            return a + ((b - a) * el) / span;
        return a - ((a - b) * el) / span;
    endfunction

    function automatic envelope_t envelope_at(sample_t s);
        longint unsigned t, e_dly, e_att, e_hold, e_dec, e_rel;
        longint unsigned ini, dly, att, pk, hld, dcy, sus, rel, v;
        envelope_t r;
        ini = env_regs[REG_INIT];    dly = env_regs[REG_DELAY];
        att = env_regs[REG_ATTACK];  pk  = env_regs[REG_PEAK];
        hld = env_regs[REG_HOLD];    dcy = env_regs[REG_DECAY];
        sus = env_regs[REG_SUSTAIN]; rel = env_regs[REG_RELEASE];
        t = longint'(s.idx) * 1000;
        r.fin = 1'b0;
        if (s.act)
        begin
            e_dly = dly * SR;
            e_att = (dly + att) * SR;
            e_hold = (dly + att + hld) * SR;
            e_dec = (dly + att + hld + dcy) * SR;
            if (t <= e_dly)
                v = ini;
            else if (t <= e_att)
                v = ramp_level(ini, pk, t - e_dly, att * SR);
            else if (t <= e_hold)
                v = pk;
            else if (t <= e_dec)
                v = ramp_level(pk, sus, t - e_hold, dcy * SR);
            else
                v = sus;
        end
        else
        begin
            e_rel = rel * SR;
            if (t <= e_rel)
                v = ramp_level(sus, END_LVL, t, e_rel);
            else
            begin
                v = END_LVL;
                r.fin = 1'b1;
            end
        end
        r.lvl = v[LVL_W-1:0];
        return r;
    endfunction

    // aim often at segment edges, where off-by-one errors live
    function automatic sample_t random_sample();
        sample_t s;
        longint unsigned edges [5];
        longint unsigned b, span;
        int pick;
        edges[0] = env_regs[REG_DELAY];
        edges[1] = edges[0] + env_regs[REG_ATTACK];
        edges[2] = edges[1] + env_regs[REG_HOLD];
        edges[3] = edges[2] + env_regs[REG_DECAY];
        edges[4] = env_regs[REG_RELEASE];
        s.act = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            b = edges[s.act ? $urandom_range(0, 3) : 4] * 48;
            b = b + $urandom_range(0, 2);
            s.idx = (b == 0) ? '0 : IDX_W'(b - 1);
        end
        else if (pick < 80)
        begin
            span = (s.act ? edges[3] : edges[4]) * 48 + 100;
            s.idx = IDX_W'({$urandom, $urandom} % span);
        end
        else
            s.idx = $urandom;
        return s;
    endfunction

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [LVL_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx < NREGS)
            env_regs[idx[2:0]] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(logic [LVL_W-1:0] v [NREGS]);
        write_reg(REG_INIT, v[0]);
        write_reg(REG_DELAY, v[1]);
        write_reg(REG_ATTACK, v[2]);
        write_reg(REG_PEAK, v[3]);
        write_reg(REG_HOLD, v[4]);
        write_reg(REG_DECAY, v[5]);
        write_reg(REG_SUSTAIN, v[6]);
        write_reg(REG_RELEASE, v[7]);
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || start || expected_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(logic [IDX_W-1:0] idx, logic act);
        sample_t s;
        s.idx = idx;
        s.act = act;
        pending_samples.push_back(s);
    endtask

    always @(posedge clk)
    begin
        sample_t nxt;
        logic go;
        if (start && !busy)
            expected_levels.push_back(envelope_at('{sample_index, active_phase}));
        go = (start && busy) ? 1'b1 : 1'b0;
        if (!(start && busy))
        begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                nxt = pending_samples.pop_front();
                sample_index <= nxt.idx;
                active_phase <= nxt.act;
                go = 1'b1;
            end
        end
        start <= go;
    end

    always @(posedge clk)
    begin
        envelope_t e;
        if (rst_n && done)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("result with nothing expected: level %0d finished %0b", level, finished);
                mismatches++;
            end
            else
            begin
                e = expected_levels.pop_front();
                levels_checked++;
                if (finished)
                    finished_seen++;
                if (level !== e.lvl)
                begin
                    $error("level: expected %0d, got %0d", e.lvl, level);
                    mismatches++;
                end
                if (finished !== e.fin)
                begin
                    $error("finished: expected %0b, got %0b", e.fin, finished);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [LVL_W-1:0] setting [NREGS];
        env_regs = '{16'd0, 16'd0, 16'd5, 16'd32768, 16'd0, 16'd50, 16'd16384, 16'd50};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: attack ends at 240, decay at 2640, release at 2400
        queue_sample(0, 1);          queue_sample(1, 1);
        queue_sample(120, 1);        queue_sample(240, 1);
        queue_sample(241, 1);        queue_sample(1000, 1);
        queue_sample(2640, 1);       queue_sample(2641, 1);
        queue_sample('1, 1);         queue_sample(0, 0);
        queue_sample(1, 0);          queue_sample(1200, 0);
        queue_sample(2400, 0);       queue_sample(2401, 0);
        queue_sample('1, 0);
        drain();
        write_reg(REG_UNUSED, 16'hFFFF);
        queue_sample(100, 1);
        queue_sample(100, 0);
        drain();

        for (int k = 0; k < 12; k++)
        begin
            for (int r = 0; r < NREGS; r++)
            begin
                if (k == 0)
                    setting[r] = '0;
                else if (k == 1)
                    setting[r] = '1;
                else if (r == 0 || r == 3 || r == 6)
                    setting[r] = LVL_W'($urandom);
                else
                    setting[r] = ($urandom_range(0, 9) == 0) ? LVL_W'($urandom) :
                                                               LVL_W'($urandom_range(0, 120));
            end
            apply_setting(setting);
            sender_idle_pct = (k < 4) ? 37 : (k < 8) ? 67 : 0;
            for (int n = 0; n < 120; n++)
                pending_samples.push_back(random_sample());
            drain();
        end

        $display("checked %0d levels over 13 register settings, %0d with release finished",
                 levels_checked, finished_seen);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/dahdsr_pkg.sv
rtl/core/dahdsr_seg.sv
rtl/core/dahdsr_div_stage.sv
rtl/core/dahdsr_envelope_level.sv
tb/tb_dahdsr_envelope_level.sv
